// ===== design/calf_pkg.sv =====
// shared types, constants and helpers for the cidr access list filter
package calf_pkg;

  // default table depth and fixed constants
  localparam int unsigned MaxRules     = 16;
  localparam logic [31:0] LoopbackAddr = 32'h7F00_0001;
  localparam logic [5:0]  HostPrefix   = 6'd32;

  // operation codes
  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_ADD   = 2'd1,
    OP_LOAD  = 2'd2
  } calf_op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } calf_status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_WRITE = 2'd2,
    S_RESP  = 2'd3
  } calf_state_e;

  // request payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic        allow_rule;
  } calf_req_t;

  // result payload
  typedef struct packed {
    logic       allowed;
    logic [1:0] status;
  } calf_rsp_t;

  // one stored rule
  typedef struct packed {
    logic [31:0] base;
    logic [5:0]  prefix;
    logic        deny;
  } calf_rule_t;

  // network mask for a prefix length, longer prefixes saturate to a host mask
  function automatic logic [31:0] prefix_mask(logic [5:0] plen);
    logic [5:0] p;
    p = (plen > HostPrefix) ? HostPrefix : plen;
    return 32'hFFFF_FFFF << (HostPrefix - p);
  endfunction

endpackage

// ===== design/calf_ram.sv =====
// generic single-port-write ram with registered read
module calf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cidr_access_list_filter_top.sv =====
// cidr access list filter: rule table in ram, one masked comparator walks the rules
// sequence: a check, or an add, reads every stored rule from the ram through the comparator;
//   an add that is no duplicate then takes the write step, as a load does straight away,
//   and an unused operation code goes straight to the result
// flow: one request at a time; the next is taken the cycle after the result is loaded,
//   and a result that waits in the output register holds the next request back
// reset: rule count cleared, always-allowed address set to 127.0.0.1, rule ram not cleared
module cidr_access_list_filter_top
  import calf_pkg::*;
#(
  parameter int unsigned MAX_RULES = MaxRules
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  calf_req_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output calf_rsp_t   out_data_o
);

  localparam int unsigned Cw = $clog2(MAX_RULES + 1);
  localparam int unsigned Aw = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned Rw = $bits(calf_rule_t);

  calf_state_e  state_q, state_d;
  logic [1:0]   op_q;
  logic [31:0]  addr_q;
  logic [5:0]   plen_q;
  logic         deny_q;
  logic [Cw-1:0] idx_q;
  logic [Cw-1:0] count_q;
  logic         pend_q;
  logic         allow_hit_q, deny_hit_q, dup_q;
  calf_status_e status_q;
  logic [31:0]  always_allowed_q;
  logic         out_valid_q;
  calf_rsp_t    out_q;

  logic         issue, scan_done, accept, load_out, table_full, ram_we, cmp_hit;
  logic [31:0]  cmp_mask;
  logic [Rw-1:0] rd_data;
  calf_rule_t   rule;
  calf_rule_t   new_rule;
  calf_rsp_t    rsp;

  // rule table
  calf_ram #(
    .Width (Rw),
    .Depth (MAX_RULES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[Aw-1:0]),
    .wdata_i (new_rule),
    .raddr_i (idx_q[Aw-1:0]),
    .rdata_o (rd_data)
  );

  // shared masked comparator; add uses the full address as a duplicate test
  assign rule     = calf_rule_t'(rd_data);
  assign cmp_mask = (op_q == OP_ADD) ? 32'hFFFF_FFFF : prefix_mask(rule.prefix);
  assign cmp_hit  = ((addr_q ^ rule.base) & cmp_mask) == 32'h0;

  assign new_rule   = '{base: addr_q, prefix: plen_q, deny: deny_q};
  assign table_full = count_q >= Cw'(MAX_RULES);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.operation inside {OP_CHECK, OP_ADD}) begin
            state_d = S_SCAN;
          end else if (in_data_i.operation == OP_LOAD) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = (op_q == OP_ADD && !dup_q) ? S_WRITE : S_RESP;
        end
      end
      S_WRITE: state_d = S_RESP;
      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    accept     = in_ready_o && in_valid_i;
    issue      = (state_q == S_SCAN) && (idx_q < count_q);
    scan_done  = (state_q == S_SCAN) && !issue && !pend_q;
    ram_we     = (state_q == S_WRITE) && !table_full;
    load_out   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  end

  // verdict and status of the finished request
  always_comb begin
    rsp.allowed = (op_q == OP_CHECK) && !deny_hit_q
                  && (allow_hit_q || addr_q == always_allowed_q);
    rsp.status  = status_q;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      always_allowed_q <= LoopbackAddr;
    end else if (cfg_we_i) begin
      always_allowed_q <= cfg_wdata_i;
    end
  end

  // scan control and rule count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      pend_q <= issue;
      if (accept) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + Cw'(1);
      end
      if (ram_we) begin
        count_q <= count_q + Cw'(1);
      end
    end
  end

  // request latch, match flags and status
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= in_data_i.operation;
      addr_q      <= in_data_i.address;
      plen_q      <= (in_data_i.prefix_len > HostPrefix) ? HostPrefix : in_data_i.prefix_len;
      deny_q      <= !in_data_i.allow_rule;
      allow_hit_q <= 1'b0;
      deny_hit_q  <= 1'b0;
      dup_q       <= 1'b0;
      status_q    <= ST_DONE;
    end else begin
      if (pend_q && cmp_hit) begin
        if (op_q == OP_ADD) begin
          dup_q <= 1'b1;
        end else if (rule.deny) begin
          deny_hit_q <= 1'b1;
        end else begin
          allow_hit_q <= 1'b1;
        end
      end
      if (scan_done && op_q == OP_ADD && dup_q) begin
        status_q <= ST_DUPLICATE;
      end
      if (state_q == S_WRITE) begin
        status_q <= table_full ? ST_FULL : ST_DONE;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/calf_checker.sv =====
// port-level checker for the cidr access list filter, bound to the top level
module calf_checker
  import calf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input calf_rsp_t out_data_i
);

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // one request at a time: ready drops after a request is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // only a check can be allowed, and a check always reports done
  a_allowed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.allowed |-> out_data_i.status == ST_DONE)
    else $error("allowed verdict with nonzero status");

  // status never carries the unused code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.status == ST_DONE || out_data_i.status == ST_DUPLICATE
                     || out_data_i.status == ST_FULL))
    else $error("bad status code");

endmodule

bind cidr_access_list_filter_top calf_checker u_calf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
